FILE: rtl/chkv_pkg.sv
package chkv_pkg;

  localparam int BUCKETS     = 64;
  localparam int CAPACITY    = 256;
  localparam int KEY_BITS    = 32;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS  = SLOT_BITS + 1;
  localparam int LIMIT_BITS  = 9;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_PUT    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 ent_we;
    logic                 val_we;
    logic [SLOT_BITS-1:0] wr_addr;
    logic [KEY_BITS-1:0]  wr_key;
    logic [SLOT_BITS-1:0] wr_link;
    logic                 wr_link_valid;
    logic [63:0]          wr_value;
  } pool_req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [SLOT_BITS-1:0] link;
    logic                 link_valid;
    logic [63:0]          value;
  } pool_rsp_t;

endpackage

FILE: rtl/chkv_pool.sv
module chkv_pool (
  input  logic                clk,
  input  chkv_pkg::pool_req_t pool_req,
  output chkv_pkg::pool_rsp_t pool_rsp
);

  localparam int EntW = chkv_pkg::KEY_BITS + chkv_pkg::SLOT_BITS + 1;

  logic [EntW-1:0] ent_mem [chkv_pkg::CAPACITY];
  logic [63:0]     val_mem [chkv_pkg::CAPACITY];
  logic [EntW-1:0] ent_rd;
  logic [63:0]     val_rd;

  always_ff @(posedge clk) begin
    if (pool_req.ent_we) begin
      ent_mem[pool_req.wr_addr] <= {pool_req.wr_key, pool_req.wr_link, pool_req.wr_link_valid};
    end
    if (pool_req.rd_en) begin
      ent_rd <= ent_mem[pool_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_req.val_we) begin
      val_mem[pool_req.wr_addr] <= pool_req.wr_value;
    end
    if (pool_req.rd_en) begin
      val_rd <= val_mem[pool_req.rd_addr];
    end
  end

  assign pool_rsp.key        = ent_rd[EntW-1 -: chkv_pkg::KEY_BITS];
  assign pool_rsp.link       = ent_rd[chkv_pkg::SLOT_BITS:1];
  assign pool_rsp.link_valid = ent_rd[0];
  assign pool_rsp.value      = val_rd;

endmodule

FILE: rtl/chained_hash_key_value_map.sv
// Chained hash key-value map.
// Request channel: req (cmd, key, value) is taken at a rising edge with start
// high and busy low. busy stays high until the request is finished.
// Commands: lookup, put (update in place or insert at the bucket head), clear; other codes just respond.
// Response channel: rsp (found, read_value, status) is valid for exactly one
// cycle with done high; there is no backpressure, the receiver must take it.
// One response per request.
// A request goes through S_HEAD and then S_ENT for each chain entry compared;
// done is registered from the last of these states. Clear and a miss on an empty
// bucket skip S_ENT. A new request may be accepted in the cycle done is high. The
// walk is set by the single read port of the entry pool and one key compare per
// cycle.
// Config: cfg_data (max_entries) is written when cfg_valid is high;
// cfg_ready is always high. Write only while idle.
// Reset (rst, synchronous): all buckets empty, no entries, max_entries 256,
// no request in flight, done low.
module chained_hash_key_value_map (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  chkv_pkg::req_t          req,
  output logic                    done,
  output chkv_pkg::rsp_t          rsp,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [chkv_pkg::LIMIT_BITS-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_HEAD, S_ENT} state_t;

  state_t                                  state, state_next;
  logic [chkv_pkg::LIMIT_BITS-1:0]         max_entries;
  logic [chkv_pkg::COUNT_BITS-1:0]         entry_count, entry_count_next;
  logic [chkv_pkg::BUCKETS-1:0]            bucket_valid, bucket_valid_next;
  logic [chkv_pkg::SLOT_BITS-1:0]          head_mem [chkv_pkg::BUCKETS];
  logic [chkv_pkg::SLOT_BITS-1:0]          head_rd;
  logic [chkv_pkg::SLOT_BITS-1:0]          cur, cur_next;
  logic [1:0]                              op_cmd;
  logic [chkv_pkg::KEY_BITS-1:0]           op_key;
  logic [63:0]                             op_value;
  logic                                    done_next;
  chkv_pkg::rsp_t                          rsp_next;
  chkv_pkg::pool_req_t                     pool_req;
  chkv_pkg::pool_rsp_t                     pool_rsp;
  logic                                    head_we;
  logic                                    accept;
  logic                                    miss;
  logic                                    full;
  logic [chkv_pkg::BUCKET_BITS-1:0]        op_bucket;
  logic [chkv_pkg::BUCKET_BITS-1:0]        req_bucket;

  assign accept     = start && !busy;
  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign op_bucket  = op_key[chkv_pkg::BUCKET_BITS-1:0];
  assign req_bucket = req.key[chkv_pkg::BUCKET_BITS-1:0];
  assign full       = (entry_count >= chkv_pkg::COUNT_BITS'(max_entries)) ||
                      (entry_count >= chkv_pkg::COUNT_BITS'(chkv_pkg::CAPACITY));

  chkv_pool u_pool (
    .clk      (clk),
    .pool_req (pool_req),
    .pool_rsp (pool_rsp)
  );

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[op_bucket] <= entry_count[chkv_pkg::SLOT_BITS-1:0];
    end
    if (accept) begin
      head_rd <= head_mem[req_bucket];
    end
  end

  always_comb begin
    state_next        = state;
    entry_count_next  = entry_count;
    bucket_valid_next = bucket_valid;
    cur_next          = cur;
    done_next         = 1'b0;
    rsp_next          = '0;
    head_we           = 1'b0;
    miss              = 1'b0;
    pool_req          = '0;
    pool_req.wr_key   = op_key;
    pool_req.wr_link  = head_rd;
    pool_req.wr_value = op_value;
    pool_req.wr_link_valid = bucket_valid[op_bucket];
    pool_req.wr_addr  = entry_count[chkv_pkg::SLOT_BITS-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (op_cmd != chkv_pkg::CMD_LOOKUP && op_cmd != chkv_pkg::CMD_PUT) begin
          if (op_cmd == chkv_pkg::CMD_CLEAR) begin
            bucket_valid_next = '0;
            entry_count_next  = '0;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (bucket_valid[op_bucket]) begin
          pool_req.rd_en   = 1'b1;
          pool_req.rd_addr = head_rd;
          cur_next         = head_rd;
          state_next       = S_ENT;
        end else begin
          miss = 1'b1;
        end
      end
      S_ENT: begin
        if (pool_rsp.key == op_key) begin
          rsp_next.found = 1'b1;
          if (op_cmd == chkv_pkg::CMD_LOOKUP) begin
            rsp_next.read_value = pool_rsp.value;
          end else begin
            pool_req.val_we  = 1'b1;
            pool_req.wr_addr = cur;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (pool_rsp.link_valid) begin
          pool_req.rd_en   = 1'b1;
          pool_req.rd_addr = pool_rsp.link;
          cur_next         = pool_rsp.link;
        end else begin
          miss = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (miss) begin
      done_next  = 1'b1;
      state_next = S_IDLE;
      if (op_cmd == chkv_pkg::CMD_PUT) begin
        if (full) begin
          rsp_next.status = 1'b1;
        end else begin
          pool_req.ent_we = 1'b1;
          pool_req.val_we = 1'b1;
          head_we         = 1'b1;
          bucket_valid_next[op_bucket] = 1'b1;
          entry_count_next = entry_count + chkv_pkg::COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_entries  <= chkv_pkg::LIMIT_BITS'(256);
      entry_count  <= '0;
      bucket_valid <= '0;
      done         <= 1'b0;
      rsp          <= '0;
    end else begin
      state        <= state_next;
      entry_count  <= entry_count_next;
      bucket_valid <= bucket_valid_next;
      done         <= done_next;
      rsp          <= rsp_next;
      if (cfg_valid && cfg_ready) begin
        max_entries <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (accept) begin
      op_cmd   <= req.cmd;
      op_key   <= req.key[chkv_pkg::KEY_BITS-1:0];
      op_value <= req.value;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy && !done)
    else $error("accepted request not in progress");
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back to back responses");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
      entry_count <= chkv_pkg::COUNT_BITS'(chkv_pkg::CAPACITY))
    else $error("entry count beyond capacity");
  a_full_rsp: assert property (@(posedge clk) disable iff (rst)
      done && rsp.status |-> !rsp.found && rsp.read_value == '0)
    else $error("refused put with data");

endmodule
